// ===== sv/cdre_pkg.sv =====
// ----------------------------------------------------------------------------
// cdre_pkg
// types, constants and saturating helpers for the lens projection pipeline
// ----------------------------------------------------------------------------
`default_nettype none

package cdre_pkg;

  localparam int QF      = 28;
  localparam int DIV_W   = 60;
  localparam int MUL_LAT = 4;
  localparam int NPH     = 6;
  localparam int NLANE   = 4;
  localparam int CFG_IW  = 4;

  typedef logic signed [63:0] q_t;

  localparam q_t LIM   = 64'sh3FFF_FFFF_FFFF_FFFF;
  localparam q_t Q_ONE = 64'sh0000_0000_1000_0000;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_DEPTH = 2'd1,
    STAT_SAT   = 2'd2
  } status_e;

  typedef enum logic [CFG_IW-1:0] {
    CFG_FOCAL_X = 4'd0,
    CFG_FOCAL_Y = 4'd1,
    CFG_PP      = 4'd2,
    CFG_K1      = 4'd3,
    CFG_K2      = 4'd4,
    CFG_K3      = 4'd5,
    CFG_P1      = 4'd6,
    CFG_P2      = 4'd7
  } cfg_idx_e;

  typedef struct packed {
    q_t   v;
    logic sat;
  } qres_t;

  typedef struct packed {
    logic signed [31:0] v;
    logic               sat;
  } c32res_t;

  typedef struct packed {
    logic               valid;
    logic               zbad;
    logic               sat;
    logic               xneg;
    logic               yneg;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic signed [31:0] ou;
    logic signed [31:0] ov;
    q_t xn;
    q_t yn;
    q_t xx;
    q_t yy;
    q_t xy2;
    q_t r2;
    q_t xx2;
    q_t yy2;
    q_t r4;
    q_t r6;
    q_t rc;
    q_t pxy;
    q_t pyx;
    q_t tx;
    q_t ty;
    q_t ptx;
    q_t pty;
    q_t xd;
    q_t yd;
    q_t u;
    q_t v;
  } ctx_t;

  function automatic qres_t addq(input q_t a, input q_t b);
    logic signed [64:0] s;
    qres_t r;
    s = 65'(a) + 65'(b);
    r.sat = 1'b0;
    if (s > 65'(LIM)) begin
      r.v = LIM;
      r.sat = 1'b1;
    end else if (s < -65'(LIM)) begin
      r.v = -LIM;
      r.sat = 1'b1;
    end else begin
      r.v = s[63:0];
    end
    return r;
  endfunction

  function automatic c32res_t clamp32(input logic signed [64:0] a);
    c32res_t r;
    r.sat = 1'b1;
    if (a > 65'sh0_7FFF_FFFF) begin
      r.v = 32'sh7FFF_FFFF;
    end else if (a < -65'sh0_8000_0000) begin
      r.v = 32'sh8000_0000;
    end else begin
      r.v = a[31:0];
      r.sat = 1'b0;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== sv/cdre_mul.sv =====
// ----------------------------------------------------------------------------
// cdre_mul
// pipelined signed fixed-point multiply, product shifted by 28 and saturated
// ----------------------------------------------------------------------------
`default_nettype none

module cdre_mul (
  input  wire logic         clk_i,
  input  wire logic         en_i,
  input  wire cdre_pkg::q_t a_i,
  input  wire cdre_pkg::q_t b_i,
  output cdre_pkg::q_t      p_o,
  output logic              sat_o
);

  logic [62:0]  ua_q, ub_q;
  logic         neg1_q, neg2_q, neg3_q;
  logic [63:0]  p00_q, p01_q, p10_q, p11_q;
  logic [127:0] prod_q;
  logic [99:0]  shr;
  logic         sat_d;
  logic [61:0]  mag_d;
  cdre_pkg::q_t p_d;
  logic [63:0]  ua_d, ub_d;

  assign ua_d = a_i[63] ? 64'(-a_i) : 64'(a_i);
  assign ub_d = b_i[63] ? 64'(-b_i) : 64'(b_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ua_q   <= ua_d[62:0];
      ub_q   <= ub_d[62:0];
      neg1_q <= a_i[63] ^ b_i[63];
      p00_q  <= 64'(ua_q[31:0]) * 64'(ub_q[31:0]);
      p01_q  <= 64'(ua_q[31:0]) * 64'({1'b0, ub_q[62:32]});
      p10_q  <= 64'({1'b0, ua_q[62:32]}) * 64'(ub_q[31:0]);
      p11_q  <= 64'({1'b0, ua_q[62:32]}) * 64'({1'b0, ub_q[62:32]});
      neg2_q <= neg1_q;
      prod_q <= 128'(p00_q) + (128'(p01_q) << 32) + (128'(p10_q) << 32)
              + (128'(p11_q) << 64);
      neg3_q <= neg2_q;
      p_o    <= p_d;
      sat_o  <= sat_d;
    end
  end

  always_comb begin
    shr   = prod_q[127:28];
    sat_d = |shr[99:62];
    mag_d = sat_d ? cdre_pkg::LIM[61:0] : shr[61:0];
    p_d   = neg3_q ? -cdre_pkg::q_t'({2'b00, mag_d}) : cdre_pkg::q_t'({2'b00, mag_d});
  end

endmodule

`default_nettype wire

// ===== sv/cdre_div.sv =====
// ----------------------------------------------------------------------------
// cdre_div
// two-lane pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
`default_nettype none

module cdre_div (
  input  wire logic                       clk_i,
  input  wire logic                       en_i,
  input  wire logic [31:0]                den_i,
  input  wire logic [cdre_pkg::DIV_W-1:0] nx_i,
  input  wire logic [cdre_pkg::DIV_W-1:0] ny_i,
  output logic      [cdre_pkg::DIV_W-1:0] qx_o,
  output logic      [cdre_pkg::DIV_W-1:0] qy_o
);

  typedef struct packed {
    logic [31:0]                rem;
    logic [cdre_pkg::DIV_W-1:0] dq;
  } dst_t;

  dst_t        x_q [cdre_pkg::DIV_W];
  dst_t        y_q [cdre_pkg::DIV_W];
  dst_t        x_d [cdre_pkg::DIV_W];
  dst_t        y_d [cdre_pkg::DIV_W];
  logic [31:0] z_q [cdre_pkg::DIV_W];

  function automatic dst_t step(input dst_t s, input logic [31:0] z);
    logic [32:0] t;
    logic [32:0] diff;
    dst_t r;
    t    = {s.rem, s.dq[cdre_pkg::DIV_W-1]};
    diff = t - {1'b0, z};
    if (t >= {1'b0, z}) begin
      r.rem = diff[31:0];
      r.dq  = {s.dq[cdre_pkg::DIV_W-2:0], 1'b1};
    end else begin
      r.rem = t[31:0];
      r.dq  = {s.dq[cdre_pkg::DIV_W-2:0], 1'b0};
    end
    return r;
  endfunction

  always_comb begin
    x_d[0] = step('{rem: 32'd0, dq: nx_i}, den_i);
    y_d[0] = step('{rem: 32'd0, dq: ny_i}, den_i);
    for (int k = 1; k < cdre_pkg::DIV_W; k++) begin
      x_d[k] = step(x_q[k-1], z_q[k-1]);
      y_d[k] = step(y_q[k-1], z_q[k-1]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      z_q[0] <= den_i;
      for (int k = 0; k < cdre_pkg::DIV_W; k++) begin
        x_q[k] <= x_d[k];
        y_q[k] <= y_d[k];
      end
      for (int k = 1; k < cdre_pkg::DIV_W; k++) begin
        z_q[k] <= z_q[k-1];
      end
    end
  end

  assign qx_o = x_q[cdre_pkg::DIV_W-1].dq;
  assign qy_o = y_q[cdre_pkg::DIV_W-1].dq;

endmodule

`default_nettype wire

// ===== sv/camera_distortion_reprojection_error_core.sv =====
// ----------------------------------------------------------------------------
// camera_distortion_reprojection_error_core
// lens distortion projection of camera-frame points with pixel residual
// ----------------------------------------------------------------------------
// usage
//   s_axis carries one point per transfer: cam_x, cam_y, cam_z, obs_u, obs_v
//   m_axis returns one result per point: pred_u, pred_v, residual_u,
//   residual_v in tdata and the status code in tuser
//   coefficients are written through cfg_we_i / cfg_idx_i / cfg_data_i while
//   no point is in flight
// timing
//   one point per cycle sustained while the output is not stalled; from input
//   transfer to output valid a point passes the input register, 60 divider
//   stages, one sign stage, six multiply phases of a four-stage 64-bit
//   multiplier plus a combine register, one tangential add and the output register
// reset
//   rst_ni clears all valid bits and loads unit focal lengths, zero
//   principal point and zero distortion
// stall
//   when m_axis_tready_i is low with a result held, the whole pipeline
//   freezes and s_axis_tready_o drops; nothing is lost or repeated
// ----------------------------------------------------------------------------
`default_nettype none

module camera_distortion_reprojection_error_core (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  wire logic [159:0]                  s_axis_tdata_i,  // cam_x, cam_y, cam_z, obs_u, obs_v
  output logic                               m_axis_tvalid_o,
  input  wire logic                          m_axis_tready_i,
  output logic [127:0]                       m_axis_tdata_o,  // pred_u, pred_v, residual_u, residual_v
  output logic [1:0]                         m_axis_tuser_o,  // status
  input  wire logic                          cfg_we_i,
  input  wire logic [cdre_pkg::CFG_IW-1:0]   cfg_idx_i,
  input  wire logic [63:0]                   cfg_data_i
);

  logic               en;
  logic [31:0]        fx_q, fy_q;
  logic [63:0]        pp_q;
  logic signed [31:0] k1_q, k2_q, k3_q, p1_q, p2_q;

  cdre_pkg::ctx_t in_q, in_d, sctx_q, sctx_d, xadd_q, xadd_d;
  cdre_pkg::ctx_t dctx_q [cdre_pkg::DIV_W];
  cdre_pkg::ctx_t mctx_q [cdre_pkg::NPH][cdre_pkg::MUL_LAT];
  cdre_pkg::ctx_t cctx_q [cdre_pkg::NPH];
  cdre_pkg::ctx_t cctx_d [cdre_pkg::NPH];
  cdre_pkg::ctx_t pin    [cdre_pkg::NPH];

  cdre_pkg::q_t ma  [cdre_pkg::NPH][cdre_pkg::NLANE];
  cdre_pkg::q_t mb  [cdre_pkg::NPH][cdre_pkg::NLANE];
  cdre_pkg::q_t mp  [cdre_pkg::NPH][cdre_pkg::NLANE];
  logic         msat[cdre_pkg::NPH][cdre_pkg::NLANE];

  logic [31:0]                nx, ny;
  logic [cdre_pkg::DIV_W-1:0] qx, qy;

  logic               out_valid_q;
  logic [127:0]       out_data_q, out_data_d;
  cdre_pkg::status_e  out_stat_q, out_stat_d;

  assign en              = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = en;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_stat_q;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fx_q <= 32'd65536;
      fy_q <= 32'd65536;
      pp_q <= '0;
      k1_q <= '0;
      k2_q <= '0;
      k3_q <= '0;
      p1_q <= '0;
      p2_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        cdre_pkg::CFG_FOCAL_X: fx_q <= cfg_data_i[31:0];
        cdre_pkg::CFG_FOCAL_Y: fy_q <= cfg_data_i[31:0];
        cdre_pkg::CFG_PP:      pp_q <= cfg_data_i;
        cdre_pkg::CFG_K1:      k1_q <= cfg_data_i[31:0];
        cdre_pkg::CFG_K2:      k2_q <= cfg_data_i[31:0];
        cdre_pkg::CFG_K3:      k3_q <= cfg_data_i[31:0];
        cdre_pkg::CFG_P1:      p1_q <= cfg_data_i[31:0];
        cdre_pkg::CFG_P2:      p2_q <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  // input stage
  always_comb begin
    in_d       = '0;
    in_d.valid = s_axis_tvalid_i;
    in_d.px    = s_axis_tdata_i[31:0];
    in_d.py    = s_axis_tdata_i[63:32];
    in_d.pz    = s_axis_tdata_i[95:64];
    in_d.ou    = s_axis_tdata_i[127:96];
    in_d.ov    = s_axis_tdata_i[159:128];
    in_d.zbad  = (in_d.pz <= 32'sd0);
    in_d.xneg  = in_d.px[31];
    in_d.yneg  = in_d.py[31];
  end

  assign nx = in_q.xneg ? 32'(-in_q.px) : 32'(in_q.px);
  assign ny = in_q.yneg ? 32'(-in_q.py) : 32'(in_q.py);

  cdre_div u_div (
    .clk_i (clk_i),
    .en_i  (en),
    .den_i (in_q.pz),
    .nx_i  ({nx, 28'd0}),
    .ny_i  ({ny, 28'd0}),
    .qx_o  (qx),
    .qy_o  (qy)
  );

  always_comb begin
    sctx_d    = dctx_q[cdre_pkg::DIV_W-1];
    sctx_d.xn = sctx_d.xneg ? -cdre_pkg::q_t'({4'd0, qx}) : cdre_pkg::q_t'({4'd0, qx});
    sctx_d.yn = sctx_d.yneg ? -cdre_pkg::q_t'({4'd0, qy}) : cdre_pkg::q_t'({4'd0, qy});
  end

  // phase inputs and multiplier operands
  always_comb begin
    for (int p = 0; p < cdre_pkg::NPH; p++) begin
      for (int l = 0; l < cdre_pkg::NLANE; l++) begin
        ma[p][l] = '0;
        mb[p][l] = '0;
      end
    end
    pin[0] = sctx_q;
    pin[1] = cctx_q[0];
    pin[2] = cctx_q[1];
    pin[3] = cctx_q[2];
    pin[4] = cctx_q[3];
    pin[5] = xadd_q;
    ma[0][0] = pin[0].xn;              mb[0][0] = pin[0].xn;
    ma[0][1] = pin[0].yn;              mb[0][1] = pin[0].yn;
    ma[0][2] = pin[0].xn;              mb[0][2] = pin[0].yn;
    ma[1][0] = pin[1].r2;              mb[1][0] = pin[1].r2;
    ma[1][1] = cdre_pkg::q_t'(k1_q);   mb[1][1] = pin[1].r2;
    ma[1][2] = cdre_pkg::q_t'(p1_q);   mb[1][2] = pin[1].xy2;
    ma[1][3] = cdre_pkg::q_t'(p2_q);   mb[1][3] = pin[1].xy2;
    ma[2][0] = pin[2].r4;              mb[2][0] = pin[2].r2;
    ma[2][1] = cdre_pkg::q_t'(k2_q);   mb[2][1] = pin[2].r4;
    ma[2][2] = cdre_pkg::q_t'(p2_q);   mb[2][2] = pin[2].tx;
    ma[2][3] = cdre_pkg::q_t'(p1_q);   mb[2][3] = pin[2].ty;
    ma[3][0] = cdre_pkg::q_t'(k3_q);   mb[3][0] = pin[3].r6;
    ma[4][0] = pin[4].xn;              mb[4][0] = pin[4].rc;
    ma[4][1] = pin[4].yn;              mb[4][1] = pin[4].rc;
    ma[5][0] = cdre_pkg::q_t'({32'd0, fx_q}); mb[5][0] = pin[5].xd;
    ma[5][1] = cdre_pkg::q_t'({32'd0, fy_q}); mb[5][1] = pin[5].yd;
  end

  for (genvar gp = 0; gp < cdre_pkg::NPH; gp++) begin : g_ph
    for (genvar gl = 0; gl < cdre_pkg::NLANE; gl++) begin : g_ln
      cdre_mul u_mul (
        .clk_i (clk_i),
        .en_i  (en),
        .a_i   (ma[gp][gl]),
        .b_i   (mb[gp][gl]),
        .p_o   (mp[gp][gl]),
        .sat_o (msat[gp][gl])
      );
    end
  end

  // phase combine stages
  always_comb begin
    cdre_pkg::qres_t r0, r1, r2, r3;
    cdre_pkg::ctx_t  c;
    logic            ms;
    for (int p = 0; p < cdre_pkg::NPH; p++) begin
      cctx_d[p] = mctx_q[p][cdre_pkg::MUL_LAT-1];
    end

    c  = cctx_d[0];
    ms = msat[0][0] | msat[0][1] | msat[0][2];
    r0 = cdre_pkg::addq(mp[0][2], mp[0][2]);
    r1 = cdre_pkg::addq(mp[0][0], mp[0][1]);
    r2 = cdre_pkg::addq(mp[0][0], mp[0][0]);
    r3 = cdre_pkg::addq(mp[0][1], mp[0][1]);
    c.xx  = mp[0][0];
    c.yy  = mp[0][1];
    c.xy2 = r0.v;
    c.r2  = r1.v;
    c.xx2 = r2.v;
    c.yy2 = r3.v;
    c.sat = c.sat | ms | r0.sat | r1.sat | r2.sat | r3.sat;
    cctx_d[0] = c;

    c  = cctx_d[1];
    ms = msat[1][0] | msat[1][1] | msat[1][2] | msat[1][3];
    r0 = cdre_pkg::addq(cdre_pkg::Q_ONE, mp[1][1]);
    r1 = cdre_pkg::addq(c.r2, c.xx2);
    r2 = cdre_pkg::addq(c.r2, c.yy2);
    c.r4  = mp[1][0];
    c.rc  = r0.v;
    c.pxy = mp[1][2];
    c.pyx = mp[1][3];
    c.tx  = r1.v;
    c.ty  = r2.v;
    c.sat = c.sat | ms | r0.sat | r1.sat | r2.sat;
    cctx_d[1] = c;

    c  = cctx_d[2];
    ms = msat[2][0] | msat[2][1] | msat[2][2] | msat[2][3];
    r0 = cdre_pkg::addq(c.rc, mp[2][1]);
    c.r6  = mp[2][0];
    c.rc  = r0.v;
    c.ptx = mp[2][2];
    c.pty = mp[2][3];
    c.sat = c.sat | ms | r0.sat;
    cctx_d[2] = c;

    c  = cctx_d[3];
    r0 = cdre_pkg::addq(c.rc, mp[3][0]);
    c.rc  = r0.v;
    c.sat = c.sat | msat[3][0] | r0.sat;
    cctx_d[3] = c;

    c  = cctx_d[4];
    r0 = cdre_pkg::addq(mp[4][0], c.pxy);
    r1 = cdre_pkg::addq(mp[4][1], c.pyx);
    c.xd  = r0.v;
    c.yd  = r1.v;
    c.sat = c.sat | msat[4][0] | msat[4][1] | r0.sat | r1.sat;
    cctx_d[4] = c;

    c  = cctx_d[5];
    r0 = cdre_pkg::addq(mp[5][0], cdre_pkg::q_t'({32'd0, pp_q[31:0]}));
    r1 = cdre_pkg::addq(mp[5][1], cdre_pkg::q_t'({32'd0, pp_q[63:32]}));
    c.u   = r0.v;
    c.v   = r1.v;
    c.sat = c.sat | msat[5][0] | msat[5][1] | r0.sat | r1.sat;
    cctx_d[5] = c;
  end

  // second tangential add
  always_comb begin
    cdre_pkg::qres_t ax, ay;
    ax          = cdre_pkg::addq(cctx_q[4].xd, cctx_q[4].ptx);
    ay          = cdre_pkg::addq(cctx_q[4].yd, cctx_q[4].pty);
    xadd_d      = cctx_q[4];
    xadd_d.xd   = ax.v;
    xadd_d.yd   = ay.v;
    xadd_d.sat  = cctx_q[4].sat | ax.sat | ay.sat;
  end

  // output formatting
  always_comb begin
    cdre_pkg::c32res_t cu, cv, ru, rv;
    cdre_pkg::ctx_t    c;
    c  = cctx_q[cdre_pkg::NPH-1];
    cu = cdre_pkg::clamp32(65'(c.u));
    cv = cdre_pkg::clamp32(65'(c.v));
    ru = cdre_pkg::clamp32(65'(c.u) - 65'(c.ou));
    rv = cdre_pkg::clamp32(65'(c.v) - 65'(c.ov));
    if (c.zbad) begin
      out_data_d = '0;
      out_stat_d = cdre_pkg::STAT_DEPTH;
    end else begin
      out_data_d = {rv.v, ru.v, cv.v, cu.v};
      if (c.sat || cu.sat || cv.sat || ru.sat || rv.sat) begin
        out_stat_d = cdre_pkg::STAT_SAT;
      end else begin
        out_stat_d = cdre_pkg::STAT_OK;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_q        <= '0;
      sctx_q      <= '0;
      xadd_q      <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
      out_stat_q  <= cdre_pkg::STAT_OK;
      for (int k = 0; k < cdre_pkg::DIV_W; k++) begin
        dctx_q[k] <= '0;
      end
      for (int p = 0; p < cdre_pkg::NPH; p++) begin
        cctx_q[p] <= '0;
        for (int s = 0; s < cdre_pkg::MUL_LAT; s++) begin
          mctx_q[p][s] <= '0;
        end
      end
    end else if (en) begin
      in_q      <= in_d;
      dctx_q[0] <= in_q;
      for (int k = 1; k < cdre_pkg::DIV_W; k++) begin
        dctx_q[k] <= dctx_q[k-1];
      end
      sctx_q <= sctx_d;
      for (int p = 0; p < cdre_pkg::NPH; p++) begin
        mctx_q[p][0] <= pin[p];
        for (int s = 1; s < cdre_pkg::MUL_LAT; s++) begin
          mctx_q[p][s] <= mctx_q[p][s-1];
        end
        cctx_q[p] <= cctx_d[p];
      end
      xadd_q      <= xadd_d;
      out_valid_q <= cctx_q[cdre_pkg::NPH-1].valid;
      out_data_q  <= out_data_d;
      out_stat_q  <= out_stat_d;
    end
  end

  a_depth_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stat_q == cdre_pkg::STAT_DEPTH |-> out_data_q == '0)
    else $error("depth fault result carries nonzero data");

  a_xn_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sctx_q.valid && !sctx_q.zbad |-> sctx_q.xn == '0 || sctx_q.xn[63] == sctx_q.xneg)
    else $error("normalized x has wrong sign");

  a_sat_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en && mctx_q[0][cdre_pkg::MUL_LAT-1].valid && mctx_q[0][cdre_pkg::MUL_LAT-1].sat
    |=> cctx_q[0].sat)
    else $error("saturation flag dropped in pipeline");

endmodule

`default_nettype wire

// ===== tb/sv/camera_distortion_reprojection_error_core_test.sv =====
// ----------------------------------------------------------------------------
// camera_distortion_reprojection_error_core_test
// self-checking bench for the lens distortion projection core, random gaps
// on input, random back-pressure on output, bit-exact fixed-point predictor
// ----------------------------------------------------------------------------
`default_nettype none

module camera_distortion_reprojection_error_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned   STALL_LIMIT = 5000;
  localparam logic [3:0]    CFG_UNUSED  = 4'd11;

  typedef struct {
    logic signed [31:0] pu;
    logic signed [31:0] pv;
    logic signed [31:0] ru;
    logic signed [31:0] rv;
    cdre_pkg::status_e  st;
  } pixel_t;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          s_axis_tvalid_i = 1'b0;
  logic          s_axis_tready_o;
  logic [159:0]  s_axis_tdata_i = '0;  // cam_x, cam_y, cam_z, obs_u, obs_v
  logic          m_axis_tvalid_o;
  logic          m_axis_tready_i = 1'b0;
  logic [127:0]  m_axis_tdata_o;       // pred_u, pred_v, residual_u, residual_v
  logic [1:0]    m_axis_tuser_o;       // status
  logic          cfg_we_i = 1'b0;
  logic [3:0]    cfg_idx_i = '0;
  logic [63:0]   cfg_data_i = '0;

  logic [31:0]        focal_x, focal_y;
  logic [63:0]        pp;
  logic signed [31:0] k1, k2, k3, p1, p2;

  pixel_t      pending_pixels[$];
  bit          idle_on = 1'b1;
  int          fails = 0;
  int unsigned quiet_cycles = 0;
  int          sink_hold = 0;

  camera_distortion_reprojection_error_core i_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i, .s_axis_tready_o, .s_axis_tdata_i,
    .m_axis_tvalid_o, .m_axis_tready_i, .m_axis_tdata_o, .m_axis_tuser_o,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  always #5 clk_i = ~clk_i;

  function automatic cdre_pkg::q_t sat_add(input cdre_pkg::q_t a, input cdre_pkg::q_t b,
                                           ref bit sat);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s > 65'(cdre_pkg::LIM)) begin
      sat = 1'b1;
      return cdre_pkg::LIM;
    end
    if (s < -65'(cdre_pkg::LIM)) begin
      sat = 1'b1;
      return -cdre_pkg::LIM;
    end
    return s[63:0];
  endfunction

  function automatic cdre_pkg::q_t fix_mul(input cdre_pkg::q_t a, input cdre_pkg::q_t b,
                                           ref bit sat);
    logic [127:0] ua, ub, prod;
    logic [63:0]  m;
    ua = {64'd0, (a < 0) ? -a : a};
    ub = {64'd0, (b < 0) ? -b : b};
    prod = (ua * ub) >> cdre_pkg::QF;
    if (prod > {64'd0, cdre_pkg::LIM}) begin
      sat = 1'b1;
      m = cdre_pkg::LIM;
    end else begin
      m = prod[63:0];
    end
    return ((a < 0) != (b < 0)) ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic signed [31:0] clip32(input logic signed [64:0] a, ref bit sat);
    if (a > 65'sh0_7FFF_FFFF) begin
      sat = 1'b1;
      return 32'sh7FFF_FFFF;
    end
    if (a < -65'sh0_8000_0000) begin
      sat = 1'b1;
      return 32'sh8000_0000;
    end
    return a[31:0];
  endfunction

  function automatic pixel_t project_point(input logic signed [31:0] x, y, z, ou, ov);
    pixel_t r;
    bit sat;
    cdre_pkg::q_t xn, yn, xx, yy, xy2, r2, r4, r6, rc, xd, yd, u, v;
    sat = 1'b0;
    if (z <= 0) begin
      r = '{0, 0, 0, 0, cdre_pkg::STAT_DEPTH};
      return r;
    end
    xn = (cdre_pkg::q_t'(x) * cdre_pkg::Q_ONE) / cdre_pkg::q_t'(z);
    yn = (cdre_pkg::q_t'(y) * cdre_pkg::Q_ONE) / cdre_pkg::q_t'(z);
    xx = fix_mul(xn, xn, sat);
    yy = fix_mul(yn, yn, sat);
    xy2 = fix_mul(xn, yn, sat);
    xy2 = sat_add(xy2, xy2, sat);
    r2 = sat_add(xx, yy, sat);
    r4 = fix_mul(r2, r2, sat);
    r6 = fix_mul(r4, r2, sat);
    rc = sat_add(cdre_pkg::Q_ONE, fix_mul(cdre_pkg::q_t'(k1), r2, sat), sat);
    rc = sat_add(rc, fix_mul(cdre_pkg::q_t'(k2), r4, sat), sat);
    rc = sat_add(rc, fix_mul(cdre_pkg::q_t'(k3), r6, sat), sat);
    xd = sat_add(fix_mul(xn, rc, sat), fix_mul(cdre_pkg::q_t'(p1), xy2, sat), sat);
    xd = sat_add(xd, fix_mul(cdre_pkg::q_t'(p2),
                             sat_add(r2, sat_add(xx, xx, sat), sat), sat), sat);
    yd = sat_add(fix_mul(yn, rc, sat), fix_mul(cdre_pkg::q_t'(p2), xy2, sat), sat);
    yd = sat_add(yd, fix_mul(cdre_pkg::q_t'(p1),
                             sat_add(r2, sat_add(yy, yy, sat), sat), sat), sat);
    u = sat_add(fix_mul($signed({32'd0, focal_x}), xd, sat), $signed({32'd0, pp[31:0]}), sat);
    v = sat_add(fix_mul($signed({32'd0, focal_y}), yd, sat), $signed({32'd0, pp[63:32]}), sat);
    r.pu = clip32({u[63], u}, sat);
    r.pv = clip32({v[63], v}, sat);
    r.ru = clip32({u[63], u} - 65'(ou), sat);
    r.rv = clip32({v[63], v} - 65'(ov), sat);
    r.st = sat ? cdre_pkg::STAT_SAT : cdre_pkg::STAT_OK;
    return r;
  endfunction

  task automatic write_reg(input logic [3:0] idx, input logic [63:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      cdre_pkg::CFG_FOCAL_X: focal_x = val[31:0];
      cdre_pkg::CFG_FOCAL_Y: focal_y = val[31:0];
      cdre_pkg::CFG_PP:      pp = val;
      cdre_pkg::CFG_K1:      k1 = val[31:0];
      cdre_pkg::CFG_K2:      k2 = val[31:0];
      cdre_pkg::CFG_K3:      k3 = val[31:0];
      cdre_pkg::CFG_P1:      p1 = val[31:0];
      cdre_pkg::CFG_P2:      p2 = val[31:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic set_lens(input logic [31:0] fx, fy, input logic [63:0] c,
                          input logic [31:0] a1, a2, a3, t1, t2);
    write_reg(cdre_pkg::CFG_FOCAL_X, {$urandom, fx});
    write_reg(cdre_pkg::CFG_FOCAL_Y, {$urandom, fy});
    write_reg(cdre_pkg::CFG_PP, c);
    write_reg(cdre_pkg::CFG_K1, {$urandom, a1});
    write_reg(cdre_pkg::CFG_K2, {$urandom, a2});
    write_reg(cdre_pkg::CFG_K3, {$urandom, a3});
    write_reg(cdre_pkg::CFG_P1, {$urandom, t1});
    write_reg(cdre_pkg::CFG_P2, {$urandom, t2});
  endtask

  task automatic send_point(input logic signed [31:0] x, y, z, ou, ov);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= {ov, ou, z, y, x};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    pending_pixels = {pending_pixels, project_point(x, y, z, ou, ov)};
  endtask

  task automatic drain;
    s_axis_tvalid_i <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic signed [31:0] scaled_word();
    return $signed($urandom) >>> $urandom_range(0, 31);
  endfunction

  function automatic logic signed [31:0] any_word();
    return ($urandom_range(0, 3) == 0) ? $signed($urandom) : scaled_word();
  endfunction

  // depth mostly positive and not far below the lateral extent
  function automatic logic signed [31:0] depth_word();
    case ($urandom_range(0, 9))
      0:       return -$signed({1'b0, $urandom_range(0, 32'h7FFF_FFFF)});
      1:       return $signed($urandom);
      2:       return 32'sd0;
      default: return $signed({1'b0, $urandom_range(32'h0001_0000, 32'h7FFF_FFFF)});
    endcase
  endfunction

  task automatic test_reset_values;
    send_point(32'sh0001_0000, 32'sh0002_0000, 32'sh0004_0000, 0, 0);
    send_point(32'sh0001_0000, 32'sh0001_0000, 32'sd0, 32'sh7FFF_FFFF, 32'sh8000_0000);
    send_point(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 1, 1);
    send_point(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd1, 0, 0);
    send_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF);
    send_point(32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000);
    send_point(0, 0, 32'sh7FFF_FFFF, 0, 0);
    send_point(-32'sh0003_0000, 32'sh0000_8000, 32'sh0010_0000, 32'sh0001_0000, -32'sd1);
    drain();
  endtask

  task automatic test_typical_lens;
    set_lens(32'h0258_0000, 32'h0258_0000, {32'h00F0_0000, 32'h0140_0000},
             -32'sh0400_0000, 32'sh0100_0000, -32'sh0010_0000, 32'sh0002_0000,
             -32'sh0001_0000);
    send_point(32'sh0001_0000, -32'sh0001_8000, 32'sh0005_0000, 32'sh01A0_0000, 32'sh0080_0000);
    send_point(-32'sh0004_0000, 32'sh0003_0000, 32'sh0006_0000, 0, 0);
    send_point(32'sh0002_0000, 32'sh0002_0000, -32'sd1, 32'sh0100_0000, 32'sh0100_0000);
    send_point(32'sh0100_0000, 32'sh0100_0000, 32'sd1, 0, 0);
    drain();
  endtask

  task automatic test_register_extremes;
    set_lens('1, '1, '1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
             32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_point(32'sh0001_0000, 32'sh0001_0000, 32'sh0002_0000, 0, 0);
    send_point(0, 0, 32'sh0001_0000, 32'sh8000_0000, 32'sh8000_0000);
    drain();
    set_lens('0, '0, '0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
             32'h8000_0000, 32'h8000_0000);
    send_point(32'sh0001_0000, -32'sh0001_0000, 32'sh0002_0000, 32'sh7FFF_FFFF, 0);
    send_point(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd1, 0, 0);
    drain();
    // zero coefficients cannot hide an overflow further up
    set_lens(32'h0001_0000, 32'h0001_0000, '0, 0, 0, 0, 0, 0);
    send_point(32'sh7FFF_FFFF, 0, 32'sd1, 0, 0);
    drain();
  endtask

  task automatic test_unused_index;
    write_reg(CFG_UNUSED, '1);
    send_point(32'sh0001_0000, 32'sh0001_0000, 32'sh0003_0000, 32'sh0000_4000, 0);
    drain();
  endtask

  task automatic test_random_phases;
    for (int ph = 0; ph < 11; ph++) begin
      if (ph == 10) idle_on = 1'b0;
      if (ph % 3 == 0) begin
        set_lens($urandom, $urandom, {$urandom, $urandom}, $urandom, $urandom, $urandom,
                 $urandom, $urandom);
      end else begin
        set_lens($urandom_range(32'h0001_0000, 32'h0800_0000),
                 $urandom_range(32'h0001_0000, 32'h0800_0000),
                 {$urandom_range(0, 32'h0400_0000), $urandom_range(0, 32'h0400_0000)},
                 scaled_word(), scaled_word() >>> 2, scaled_word() >>> 4,
                 scaled_word() >>> 6, scaled_word() >>> 6);
      end
      repeat (100) send_point(any_word(), any_word(), depth_word(), any_word(), any_word());
      drain();
    end
  endtask

  always @(posedge clk_i) begin
    if (sink_hold > 0) begin
      sink_hold <= sink_hold - 1;
      m_axis_tready_i <= 1'b0;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      sink_hold <= $urandom_range(0, 5);
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    pixel_t e;
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_pixels.size() == 0) begin
        $error("result transfer with no point outstanding");
        fails++;
      end else begin
        e = pending_pixels.pop_front();
        if (m_axis_tdata_o[31:0] !== e.pu) begin
          $error("pred_u expected %0d actual %0d", e.pu, $signed(m_axis_tdata_o[31:0]));
          fails++;
        end
        if (m_axis_tdata_o[63:32] !== e.pv) begin
          $error("pred_v expected %0d actual %0d", e.pv, $signed(m_axis_tdata_o[63:32]));
          fails++;
        end
        if (m_axis_tdata_o[95:64] !== e.ru) begin
          $error("residual_u expected %0d actual %0d", e.ru, $signed(m_axis_tdata_o[95:64]));
          fails++;
        end
        if (m_axis_tdata_o[127:96] !== e.rv) begin
          $error("residual_v expected %0d actual %0d", e.rv,
                 $signed(m_axis_tdata_o[127:96]));
          fails++;
        end
        if (m_axis_tuser_o !== e.st) begin
          $error("status expected %0d actual %0d", e.st, m_axis_tuser_o);
          fails++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("[camera_distortion_reprojection_error_core] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    focal_x = 32'h0001_0000;
    focal_y = 32'h0001_0000;
    pp = '0;
    {k1, k2, k3, p1, p2} = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_values();
    test_typical_lens();
    test_register_extremes();
    test_unused_index();
    test_random_phases();
    repeat (120) @(posedge clk_i);
    if (pending_pixels.size() != 0) begin
      $error("%0d results never arrived", pending_pixels.size());
      fails++;
    end
    if (fails == 0) begin
      $display("[camera_distortion_reprojection_error_core] OK");
    end else begin
      $display("[camera_distortion_reprojection_error_core] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
